// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/lcl_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup package
// Shared constants and control/status types of the lookup block.
// ----------------------------------------------------------------------------
package lcl_pkg;

   localparam int CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
   localparam int RSP_BITS = 8;

   typedef struct packed {
      logic load_key;
      logic lookup;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_sts_type;

endpackage

// ===== design/lcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup controller
// Sequences one word through key load, tag compare and store update.
// ----------------------------------------------------------------------------
module lcl_ctrl
   import lcl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_sts_type  sts,
   output ctl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load_key = 1'b0;
      cmd.lookup   = 1'b0;
      cmd.update   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_key = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/lcl_datapath.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup datapath
// Key store, parallel tag compare, recency ranks and result register.
// ----------------------------------------------------------------------------
module lcl_datapath
   import lcl_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [KEY_BITS-1:0] key,
   input  logic                csr_we,
   input  logic [CAP_BITS-1:0] csr_wdata,
   input  ctl_cmd_type         cmd,
   output dp_sts_type          sts,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_hit
);

   localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CW         = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;

   logic [KEY_BITS-1:0]   key_ff;
   logic [KEY_BITS-1:0]   entry_key_ff [ENTRIES];
   logic [ENTRIES-1:0]    valid_ff;
   logic [RANK_BITS-1:0]  rank_ff [ENTRIES];
   logic [COUNT_BITS-1:0] occ_ff;
   logic [CAP_BITS-1:0]   cap_ff;

   logic [ENTRIES-1:0]    slot_ff;
   logic                  hit_ff;
   logic                  grow_ff;
   logic [COUNT_BITS-1:0] limit_ff;

   logic                  out_valid_ff;
   logic                  out_hit_ff;

   logic [ENTRIES-1:0]    match;
   logic [ENTRIES-1:0]    lru;
   logic [ENTRIES-1:0]    free;
   logic [ENTRIES-1:0]    free_first;
   logic [RANK_BITS-1:0]  hit_rank;
   logic                  hit;
   logic [CW-1:0]         eff_cap;
   logic                  full;
   logic [COUNT_BITS-1:0] occ_last;

   assign sts.out_free = !out_valid_ff || out_ready;
   assign out_valid    = out_valid_ff;
   assign out_hit      = out_hit_ff;

   assign occ_last = occ_ff - COUNT_BITS'(1);

   // parallel compare: ranks stay dense, so the oldest entry is rank occupancy-1
   always_comb begin
      hit_rank = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (entry_key_ff[i] == key_ff);
         lru[i]   = valid_ff[i] && (COUNT_BITS'(rank_ff[i]) == occ_last);
         hit_rank = hit_rank | (match[i] ? rank_ff[i] : '0);
      end
   end

   assign hit        = |match;
   assign free       = ~valid_ff;
   assign free_first = free & (~free + ENTRIES'(1));

   always_comb begin
      eff_cap = CW'(cap_ff);
      if (eff_cap == '0) begin
         eff_cap = CW'(1);
      end else if (eff_cap > CW'(ENTRIES)) begin
         eff_cap = CW'(ENTRIES);
      end
   end

   assign full = CW'(occ_ff) >= eff_cap;

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= key;
      end
      if (cmd.lookup) begin
         hit_ff  <= hit;
         grow_ff <= !hit && !full;
         if (hit) begin
            slot_ff  <= match;
            limit_ff <= COUNT_BITS'(hit_rank);
         end else if (full) begin
            slot_ff  <= lru;
            limit_ff <= occ_last;
         end else begin
            slot_ff  <= free_first;
            limit_ff <= COUNT_BITS'(ENTRIES);
         end
      end
      if (cmd.update) begin
         out_hit_ff <= hit_ff;
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_ff[i]) begin
               entry_key_ff[i] <= key_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         if (cmd.update) begin
            out_valid_ff <= 1'b1;
            if (grow_ff) begin
               occ_ff <= occ_ff + COUNT_BITS'(1);
            end
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_ff[i]) begin
                  valid_ff[i] <= 1'b1;
                  rank_ff[i]  <= '0;
               end else if (valid_ff[i] && (COUNT_BITS'(rank_ff[i]) < limit_ff)) begin
                  rank_ff[i] <= rank_ff[i] + RANK_BITS'(1);
               end
            end
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== design/lru_cache_lookup.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup
// Fully associative key store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one key per word; rsp_* returns one word per key with the
//   hit flag in bit 0 (1 = key was present, 0 = miss, key now inserted).
//   A miss on a full store evicts the least recent key first.
//   csr_we/csr_wdata write the capacity; write it only while the block idles.
//   Capacity 0 acts as 1, values above ENTRIES act as ENTRIES.
// Sequence:
//   An accepted key passes the tag compare over all entries, then the rank and
//   store update, each a state of the controller; its result word is
//   registered in the output register. No new key is accepted before the
//   update of the previous key is done.
// Reset:
//   Synchronous; empties the store and sets capacity to 16. A new key is
//   taken in the cycle right after reset.
// Stall:
//   The result waits in an output register; the next key is accepted and
//   compared meanwhile, and its update holds until the register frees up.
// ----------------------------------------------------------------------------
module lru_cache_lookup
   import lcl_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((KEY_BITS + 7) / 8) * 8-1:0] req_tdata,  // key
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_BITS-1:0]                 rsp_tdata,  // hit
   input  logic                                csr_we,
   input  logic [CAP_BITS-1:0]                 csr_wdata
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;
   logic        out_hit;

   lcl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   lcl_datapath #(
      .ENTRIES  (ENTRIES),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .key       (req_tdata[KEY_BITS-1:0]),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (out_hit)
   );

   assign rsp_tdata = {{(RSP_BITS - 1){1'b0}}, out_hit};

endmodule

// ===== design/lcl_port_chk.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup port checks
// Timing and format checks on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcl_port_chk
   import lcl_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // busy for compare and update after each accepted key
   `ASSERT_NEXT(a_busy_compare, req_tvalid && req_tready, !req_tready)
   `ASSERT_SAME(a_busy_update, $past(req_tvalid && req_tready, 2), !req_tready)

   // a fresh result word follows its key through the compare and update states
   `ASSERT_SAME(a_rsp_latency, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 3))

   // only bit 0 carries the hit flag
   `ASSERT_SAME(a_rsp_pad, rsp_tvalid, rsp_tdata[RSP_BITS-1:1] == '0)

endmodule

bind lru_cache_lookup lcl_port_chk u_port_chk (.*);

// ===== test/lru_cache_lookup_test.sv =====
// ----------------------------------------------------------------------------
// LRU cache lookup testbench
// Streams keys into the lookup block under random idling on both sides and
// rewrites the capacity between phases. A recency tracker mirrors the store,
// predicts the hit flag of every accepted key and checks each result word.
// ----------------------------------------------------------------------------
module lru_cache_lookup_test
   import lcl_pkg::*;
();

   localparam int SLOTS       = 16;
   localparam int KEY_W       = 16;
   localparam int ITEM_GOAL   = 1850;
   localparam int CYCLE_LIMIT = 400000;

   // Recency tracker: mirrors the store contents and queues the hit flag
   // expected for each accepted key.
   class recency_tracker;
      logic [KEY_W-1:0]    slot_key[SLOTS];
      bit                  slot_valid[SLOTS];
      int                  slot_rank[SLOTS];
      int                  occupancy;
      logic [CAP_BITS-1:0] capacity;
      bit                  hits_due[$];
      int                  failures;

      function new();
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
            slot_key[i]   = '0;
         end
         occupancy = 0;
         capacity  = CAP_RESET;
         failures  = 0;
      endfunction

      function void set_capacity(logic [CAP_BITS-1:0] value);
         capacity = value;
      endfunction

      function int room();
         int c;
         c = capacity;
         if (c < 1) c = 1;
         if (c > SLOTS) c = SLOTS;
         return c;
      endfunction

      // age every valid slot whose rank is below the limit
      function void age_below(int limit);
         foreach (slot_valid[i])
            if (slot_valid[i] && slot_rank[i] < limit) slot_rank[i]++;
      endfunction

      function void note_key(logic [KEY_W-1:0] key);
         int slot;
         int worst;
         slot = -1;
         worst = 0;
         foreach (slot_valid[i])
            if (slot == -1 && slot_valid[i] && slot_key[i] == key) slot = i;
         if (slot >= 0) begin
            age_below(slot_rank[slot]);
            slot_rank[slot] = 0;
            hits_due.push_back(1'b1);
            return;
         end
         if (occupancy >= room()) begin
            // evict the least recent key; occupancy stays put
            foreach (slot_valid[i])
               if (slot_valid[i] && (slot < 0 || slot_rank[i] > worst)) begin
                  slot  = i;
                  worst = slot_rank[i];
               end
            if (slot >= 0) begin
               slot_valid[slot] = 1'b0;
               age_below(worst);
            end
         end else begin
            foreach (slot_valid[i])
               if (slot == -1 && !slot_valid[i]) slot = i;
            if (slot >= 0) begin
               age_below(SLOTS);
               occupancy++;
            end
         end
         if (slot >= 0) begin
            slot_key[slot]   = key;
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = 0;
         end
         hits_due.push_back(1'b0);
      endfunction

      function void check_word(logic [RSP_BITS-1:0] word);
         logic [RSP_BITS-1:0] want;
         if (hits_due.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected result word %h", word);
            return;
         end
         want = {{(RSP_BITS-1){1'b0}}, hits_due.pop_front()};
         if (word !== want) begin
            failures++;
            if (failures <= 10)
               $display("hit mismatch: expected %h, got %h", want, word);
         end
      endfunction

      function int pending();
         return hits_due.size();
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [KEY_W-1:0]          req_tdata = '0;   // key
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;        // hit
   logic                      csr_we = 1'b0;
   logic [CAP_BITS-1:0]       csr_wdata = '0;

   recency_tracker tracker = new();
   bit             idle_on = 1'b0;
   int             cycles  = 0;

   lru_cache_lookup #(
      .ENTRIES  (SLOTS),
      .KEY_BITS (KEY_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Hold valid after acceptance; the next send or settle decides its level.
   task automatic send_key(input logic [KEY_W-1:0] key);
      int gap;
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= key;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_key(key);
   endtask

   // Drop valid and wait until every expected word is back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      tracker.set_capacity(value);
   endtask

   initial begin : rsp_side
      int stall;
      wait (reset === 1'b0);
      forever begin
         stall = idle_on ? $urandom_range(0, 15) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         tracker.check_word(rsp_tdata);
      end
   end

   initial begin : req_side
      logic [CAP_BITS-1:0] cap_plan[10];
      logic [CAP_BITS-1:0] cap;
      logic [KEY_W-1:0]    pool[$];
      logic [KEY_W-1:0]    key;
      int                  sent;
      int                  phase;
      int                  count;
      int                  eff;
      int                  pool_size;
      cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd4, 5'd15, 5'd8, 5'd3};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill the store at reset capacity, then evict the least recent keys
      send_key(16'h0000);
      send_key(16'hFFFF);
      send_key(16'h0000);
      send_key(16'h5555);
      send_key(16'hAAAA);
      for (int i = 0; i < 12; i++) send_key(KEY_W'(16'h0100 + i));
      send_key(16'h1234);
      send_key(16'hFFFF);
      // capacity zero acts as one; occupancy stays above it
      write_capacity(5'd0);
      send_key(16'h0000);
      send_key(16'h0001);
      send_key(16'h0001);
      idle_on = 1'b1;
      // capacity above the slot count saturates
      write_capacity(5'd31);
      send_key(16'h0002);
      send_key(16'h0003);
      send_key(16'h0000);
      sent = 25;

      phase = 0;
      while (sent < ITEM_GOAL) begin
         cap = (phase < 10) ? cap_plan[phase] : 5'($urandom_range(0, 31));
         write_capacity(cap);
         idle_on = ($urandom_range(0, 3) != 0);
         eff = (cap == 0) ? 1 : (cap > SLOTS) ? SLOTS : cap;
         pool.delete();
         pool_size = eff + $urandom_range(0, 6);
         for (int i = 0; i < pool_size; i++) pool.push_back(KEY_W'($urandom));
         count = $urandom_range(60, 160);
         for (int i = 0; i < count; i++) begin
            if (phase == 5 && i == count / 2) settle();
            if ($urandom_range(0, 99) < 85) key = pool[$urandom_range(0, pool.size() - 1)];
            else key = KEY_W'($urandom);
            send_key(key);
         end
         sent += count;
         phase++;
      end

      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== lru_cache_lookup.f =====
+incdir+design
design/lcl_pkg.sv
design/lcl_ctrl.sv
design/lcl_datapath.sv
design/lru_cache_lookup.sv
design/lcl_port_chk.sv
test/lru_cache_lookup_test.sv
